// ----- src/serial_mouse_packet_decoder_top_macros.svh -----
// ----------------------------------------------------------------------------
// Serial mouse packet decoder assertion macros
// Short forms for clocked implication checks with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef SERIAL_MOUSE_PACKET_DECODER_TOP_MACROS_SVH
`define SERIAL_MOUSE_PACKET_DECODER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMPD_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SMPD_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/smpd_pkg.sv -----
// ----------------------------------------------------------------------------
// Serial mouse packet decoder package
// Event codes, packet layout constants and the packet record type.
// ----------------------------------------------------------------------------
`default_nettype none

package smpd_pkg;

  typedef enum logic [1:0] {
    EV_DOWN = 2'd0,
    EV_UP   = 2'd1,
    EV_MOVE = 2'd2
  } smpd_kind_e;

  localparam logic [1:0] BTN_NONE = 2'd0;
  localparam logic [1:0] BTN_ONE  = 2'd1;
  localparam logic [1:0] BTN_TWO  = 2'd2;

  // Position values within a packet.
  localparam logic [2:0] POS_HEADER = 3'd0;
  localparam logic [2:0] POS_SECOND = 3'd1;
  localparam logic [2:0] POS_THIRD  = 3'd2;
  localparam logic [2:0] POS_DONE   = 3'd4;

  // Header bit positions.
  localparam int unsigned SYNC_BIT = 6;
  localparam int unsigned BTN1_BIT = 5;
  localparam int unsigned BTN2_BIT = 4;

  // Pending event mask bits.
  localparam int unsigned EVB_BTN1 = 0;
  localparam int unsigned EVB_BTN2 = 1;
  localparam int unsigned EVB_MOVE = 2;

  typedef struct packed {
    logic [2:0]        ev_mask;   // events still to be sent
    logic [1:0]        btn_down;  // new button state, bit 0 button 1
    logic signed [7:0] dx;
    logic signed [7:0] dy;
  } smpd_rec_t;

endpackage

`default_nettype wire

// ----- src/smpd_if.sv -----
// ----------------------------------------------------------------------------
// Serial mouse packet decoder channel interfaces
// Valid/ready channels for received bytes and for mouse events.
// ----------------------------------------------------------------------------
`default_nettype none

interface smpd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface smpd_ev_if;
  logic              valid;
  logic              ready;
  logic [1:0]        event_kind;
  logic [1:0]        button_id;
  logic signed [7:0] delta_x;
  logic signed [7:0] delta_y;
  logic              last;

  modport source (output valid, output event_kind, output button_id,
                  output delta_x, output delta_y, output last, input ready);
  modport sink   (input valid, input event_kind, input button_id,
                  input delta_x, input delta_y, input last, output ready);
endinterface

`default_nettype wire

// ----- src/smpd_decode.sv -----
// ----------------------------------------------------------------------------
// Serial mouse packet decoder byte stage
// Tracks packet position; each completed packet with events becomes a record.
// ----------------------------------------------------------------------------
`default_nettype none

module smpd_decode (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  smpd_rx_if.sink                rx,
  input  wire logic              rec_take_i,
  output logic                   rec_valid_o,
  output smpd_pkg::smpd_rec_t    rec_o
);

  logic [2:0]          pos_q, pos_d;
  logic [7:0]          hdr_q, hdr_d;
  logic [7:0]          sec_q, sec_d;
  logic [1:0]          prev_q, prev_d;
  logic                rec_valid_q, rec_valid_d;
  smpd_pkg::smpd_rec_t rec_q, rec_d;

  logic                accept;
  logic [2:0]          pos;
  logic [1:0]          buttons;
  logic [1:0]          changed;
  logic signed [7:0]   dx;
  logic signed [7:0]   dy;

  // The record slot frees up in the same cycle the serializer takes it.
  assign rx.ready = !rec_valid_q || rec_take_i;
  assign accept   = rx.valid && rx.ready;

  assign pos     = rx.rx_byte[smpd_pkg::SYNC_BIT] ? smpd_pkg::POS_HEADER : pos_q;
  assign buttons = {hdr_q[smpd_pkg::BTN2_BIT], hdr_q[smpd_pkg::BTN1_BIT]};
  assign changed = buttons ^ prev_q;
  assign dx      = {hdr_q[1:0], sec_q[5:0]};
  assign dy      = {hdr_q[3:2], rx.rx_byte[5:0]};

  always_comb begin
    pos_d       = pos_q;
    hdr_d       = hdr_q;
    sec_d       = sec_q;
    prev_d      = prev_q;
    rec_valid_d = rec_valid_q && !rec_take_i;
    rec_d       = rec_q;
    if (accept) begin
      pos_d = pos;
      if (pos != smpd_pkg::POS_DONE) begin
        pos_d = pos + 3'd1;
        if (pos == smpd_pkg::POS_HEADER) begin
          hdr_d = rx.rx_byte;
        end else if (pos == smpd_pkg::POS_SECOND) begin
          sec_d = rx.rx_byte;
        end
        if (pos == smpd_pkg::POS_THIRD) begin
          prev_d                              = buttons;
          rec_d.ev_mask[smpd_pkg::EVB_BTN1]   = changed[0];
          rec_d.ev_mask[smpd_pkg::EVB_BTN2]   = changed[1];
          rec_d.ev_mask[smpd_pkg::EVB_MOVE]   = (dx != 8'sd0) || (dy != 8'sd0);
          rec_d.btn_down                      = buttons;
          rec_d.dx                            = dx;
          rec_d.dy                            = dy;
          rec_valid_d = (changed != 2'b00) || (dx != 8'sd0) || (dy != 8'sd0);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= smpd_pkg::POS_HEADER;
      hdr_q       <= 8'h00;
      sec_q       <= 8'h00;
      prev_q      <= 2'b00;
      rec_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      hdr_q       <= hdr_d;
      sec_q       <= sec_d;
      prev_q      <= prev_d;
      rec_valid_q <= rec_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_valid_o = rec_valid_q;
  assign rec_o       = rec_q;

endmodule

`default_nettype wire

// ----- src/smpd_emit.sv -----
// ----------------------------------------------------------------------------
// Serial mouse packet decoder event serializer
// Sends a record's events via a result register, one per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module smpd_emit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              rec_valid_i,
  input  smpd_pkg::smpd_rec_t    rec_i,
  output logic                   rec_take_o,
  smpd_ev_if.source              ev
);

  logic [2:0]           pend_q, pend_d;
  logic [1:0]           down_q;
  logic signed [7:0]    dx_q;
  logic signed [7:0]    dy_q;
  logic                 out_valid_q, out_valid_d;
  smpd_pkg::smpd_kind_e kind_q, kind_d;
  logic [1:0]           id_q, id_d;
  logic signed [7:0]    odx_q, odx_d;
  logic signed [7:0]    ody_q, ody_d;
  logic                 last_q, last_d;

  logic                 advance;
  logic [2:0]           pend_rest;
  logic [2:0]           pend_after;

  assign advance    = (pend_q != 3'b000) && (!out_valid_q || ev.ready);
  assign pend_rest  = pend_q & (pend_q - 3'd1);
  assign pend_after = advance ? pend_rest : pend_q;
  assign rec_take_o = rec_valid_i && (pend_after == 3'b000);

  always_comb begin
    pend_d      = rec_take_o ? rec_i.ev_mask : pend_after;
    out_valid_d = out_valid_q && !ev.ready;
    kind_d      = kind_q;
    id_d        = id_q;
    odx_d       = odx_q;
    ody_d       = ody_q;
    last_d      = last_q;
    if (advance) begin
      out_valid_d = 1'b1;
      last_d      = (pend_rest == 3'b000);
      odx_d       = 8'sd0;
      ody_d       = 8'sd0;
      if (pend_q[smpd_pkg::EVB_BTN1]) begin
        kind_d = down_q[0] ? smpd_pkg::EV_DOWN : smpd_pkg::EV_UP;
        id_d   = smpd_pkg::BTN_ONE;
      end else if (pend_q[smpd_pkg::EVB_BTN2]) begin
        kind_d = down_q[1] ? smpd_pkg::EV_DOWN : smpd_pkg::EV_UP;
        id_d   = smpd_pkg::BTN_TWO;
      end else begin
        kind_d = smpd_pkg::EV_MOVE;
        id_d   = smpd_pkg::BTN_NONE;
        odx_d  = dx_q;
        ody_d  = dy_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 3'b000;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_take_o) begin
      down_q <= rec_i.btn_down;
      dx_q   <= rec_i.dx;
      dy_q   <= rec_i.dy;
    end
    kind_q <= kind_d;
    id_q   <= id_d;
    odx_q  <= odx_d;
    ody_q  <= ody_d;
    last_q <= last_d;
  end

  assign ev.valid      = out_valid_q;
  assign ev.event_kind = kind_q;
  assign ev.button_id  = id_q;
  assign ev.delta_x    = odx_q;
  assign ev.delta_y    = ody_q;
  assign ev.last       = last_q;

endmodule

`default_nettype wire

// ----- src/serial_mouse_packet_decoder_top.sv -----
// ----------------------------------------------------------------------------
// Serial mouse packet decoder
// Decodes a three-byte two-button serial mouse byte stream into button and
// movement events.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Carries                                        Accepted
//   rx_i      in    rx_byte                                        valid & ready
//   ev_o      out   event_kind, button_id, delta_x, delta_y, last  valid & ready
//
// One byte can be taken every cycle while rx_i.ready is high. A byte that
// completes a packet yields up to three events (none for a silent packet); the
// first reaches ev_o via the record slot, pending mask and result register, and
// the rest follow one per cycle while ev_o is not stalled. One finished packet
// record waits between the two stages, so bytes keep flowing while events are
// sent. Reset clears the packet position, stored bytes and button history. A
// stall on ev_o backs up into the record slot and then drops rx_i.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_mouse_packet_decoder_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  smpd_rx_if.sink   rx_i,
  smpd_ev_if.source ev_o
);

  // A packet record travels from the byte stage to the serializer; the
  // serializer tells the byte stage when it has taken the record so that the
  // slot can be refilled in the same cycle.
  logic                rec_valid;
  logic                rec_take;
  smpd_pkg::smpd_rec_t rec;

  // Byte stage: packet position tracking, header and second byte capture,
  // delta and button assembly when the third byte arrives.
  smpd_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx          (rx_i),
    .rec_take_i  (rec_take),
    .rec_valid_o (rec_valid),
    .rec_o       (rec)
  );

  // Serializer: button 1, button 2, then movement, with the last flag on the
  // final event of each packet.
  smpd_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (rec_valid),
    .rec_i       (rec),
    .rec_take_o  (rec_take),
    .ev          (ev_o)
  );

endmodule

`default_nettype wire

// ----- src/smpd_checker.sv -----
// ----------------------------------------------------------------------------
// Serial mouse packet decoder port checker
// Checks event channel behavior seen at the top level ports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "serial_mouse_packet_decoder_top_macros.svh"

module smpd_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              ev_valid_i,
  input wire logic              ev_ready_i,
  input wire logic [1:0]        event_kind_i,
  input wire logic [1:0]        button_id_i,
  input wire logic signed [7:0] delta_x_i,
  input wire logic signed [7:0] delta_y_i,
  input wire logic              last_i
);

  logic        ev_move;
  logic        ev_stall;
  logic [21:0] ev_bits;
  logic        valid_move;
  logic        valid_btn;
  logic        moved;
  logic        move_ok;
  logic        btn_ok;

  assign ev_move    = (event_kind_i == smpd_pkg::EV_MOVE);
  assign ev_stall   = ev_valid_i && !ev_ready_i;
  assign ev_bits    = {ev_valid_i, event_kind_i, button_id_i, delta_x_i, delta_y_i, last_i};
  assign valid_move = ev_valid_i && ev_move;
  assign valid_btn  = ev_valid_i && !ev_move;
  assign moved      = (delta_x_i != 8'sd0) || (delta_y_i != 8'sd0);
  assign move_ok    = last_i && (button_id_i == smpd_pkg::BTN_NONE);
  assign btn_ok     = !moved && ((button_id_i == smpd_pkg::BTN_ONE) ||
                                 (button_id_i == smpd_pkg::BTN_TWO));

  // A stalled event stays valid and keeps its contents.
  `SMPD_ASSERT_NXT(a_ev_hold, clk_i, rst_ni, ev_stall, $stable(ev_bits), "stalled event changed")
  // Movement is always the final event of a packet and carries no button.
  `SMPD_ASSERT_IMP(a_move_last, clk_i, rst_ni, valid_move, move_ok, "movement event malformed")
  // A movement event never has both deltas zero.
  `SMPD_ASSERT_IMP(a_move_nonzero, clk_i, rst_ni, valid_move, moved, "empty movement event")
  // Button events name a button and carry no movement.
  `SMPD_ASSERT_IMP(a_button_shape, clk_i, rst_ni, valid_btn, btn_ok, "button event malformed")

endmodule

bind serial_mouse_packet_decoder_top smpd_checker u_smpd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .ev_valid_i   (ev_o.valid),
  .ev_ready_i   (ev_o.ready),
  .event_kind_i (ev_o.event_kind),
  .button_id_i  (ev_o.button_id),
  .delta_x_i    (ev_o.delta_x),
  .delta_y_i    (ev_o.delta_y),
  .last_i       (ev_o.last)
);

`default_nettype wire

// ----- tb/serial_mouse_packet_decoder_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Serial mouse packet decoder testbench
// Streams received bytes into the decoder over the rx channel. Each accepted
// request is run through a behavioral decoder that keeps its own packet
// position, stored bytes and button history, and queues the events it
// expects. Every event taken on the ev channel is checked field by field
// against the oldest expected event. The run steps through directed packets,
// random packet streams with sync loss and noise, several idle and stall
// mixes, and one long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module serial_mouse_packet_decoder_top_test;

  // This bound only catches a block that has stopped answering.
  localparam int unsigned CYCLE_LIMIT = 200000;
  // Cycles to wait after the last expected event in case the block sends more.
  localparam int unsigned DRAIN_CYCLES = 12;
  // Length of the receiver hold-off that fills the record slot and stalls rx.
  localparam int unsigned HOLD_CYCLES = 150;

  // One mouse event as the decoder is expected to send it.
  typedef struct {
    smpd_pkg::smpd_kind_e kind;
    logic [1:0]           btn;
    logic signed [7:0]    dx;
    logic signed [7:0]    dy;
    logic                 last;
  } mouse_ev_t;

  logic clk_i;
  logic rst_ni;

  smpd_rx_if rx_ch ();
  smpd_ev_if ev_ch ();

  serial_mouse_packet_decoder_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_ch),
    .ev_o   (ev_ch)
  );

  // Bytes still to be offered; the head is the one on the bus while offering.
  logic [7:0] byte_q[$];
  // Events predicted from accepted bytes and not yet seen on the ev channel.
  mouse_ev_t  pending_events[$];

  logic running;
  logic offering;
  int   send_idle_pct;
  int   recv_stall_pct;
  bit   hold_req;
  int   hold_left;

  int unsigned cycle_count;
  int          err_count;
  int          bytes_taken;
  int          packets_done;
  int          events_seen;
  int          moves_seen;
  int          button_events_seen;

  // Decoder state as the behavioral model sees it.
  logic [2:0] pkt_pos;
  logic [7:0] hdr_byte;
  logic [7:0] mid_byte;
  logic [1:0] btn_prev;

  // Free-running clock, 4 ns period.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Cycle counter and timeout. A block that loses an event or never accepts a
  // byte ends up here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Cycle limit reached with %0d bytes queued and %0d events outstanding.",
               byte_q.size(), pending_events.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Behavioral decoder. A byte with the sync bit restarts the packet; a byte
  // taken at position zero is the header even without the sync bit, which is
  // how the very first byte after reset can start a packet. The fourth byte is
  // swallowed and anything after it waits for the next sync. The third byte
  // completes the packet: button 1 change, button 2 change, then movement if
  // either delta is nonzero, with last on the final event.
  function automatic void decode_rx_byte(input logic [7:0] b);
    mouse_ev_t         evs[$];
    logic [1:0]        btns;
    logic [1:0]        flips;
    logic signed [7:0] mx;
    logic signed [7:0] my;
    logic              at_third;
    if (b[smpd_pkg::SYNC_BIT]) pkt_pos = smpd_pkg::POS_HEADER;
    if (pkt_pos >= smpd_pkg::POS_DONE) return;
    at_third = (pkt_pos == smpd_pkg::POS_THIRD);
    if (pkt_pos == smpd_pkg::POS_HEADER) hdr_byte = b;
    else if (pkt_pos == smpd_pkg::POS_SECOND) mid_byte = b;
    pkt_pos = pkt_pos + 3'd1;
    if (!at_third) return;

    mx = {hdr_byte[1:0], mid_byte[5:0]};
    my = {hdr_byte[3:2], b[5:0]};
    btns = {hdr_byte[smpd_pkg::BTN2_BIT], hdr_byte[smpd_pkg::BTN1_BIT]};
    flips = btns ^ btn_prev;
    btn_prev = btns;
    packets_done++;

    if (flips[0])
      evs.push_back('{kind: btns[0] ? smpd_pkg::EV_DOWN : smpd_pkg::EV_UP,
                      btn: smpd_pkg::BTN_ONE, dx: '0, dy: '0, last: 1'b0});
    if (flips[1])
      evs.push_back('{kind: btns[1] ? smpd_pkg::EV_DOWN : smpd_pkg::EV_UP,
                      btn: smpd_pkg::BTN_TWO, dx: '0, dy: '0, last: 1'b0});
    if (mx != 0 || my != 0)
      evs.push_back('{kind: smpd_pkg::EV_MOVE, btn: smpd_pkg::BTN_NONE,
                      dx: mx, dy: my, last: 1'b0});
    if (evs.size() != 0) evs[evs.size() - 1].last = 1'b1;
    foreach (evs[i]) pending_events.push_back(evs[i]);
  endfunction

  // Compares one field; both values arrive sign-extended to nine bits so the
  // deltas print as signed numbers.
  function automatic void check_field(input string name, input logic signed [8:0] want_v,
                                      input logic signed [8:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      err_count++;
    end
  endfunction

  // Appends random mouse traffic. Most of it is well-formed packets with random
  // content, some with a fourth byte and trailing junk; the rest is packets cut
  // short by a new sync and loose noise bytes. About a quarter of the packets
  // carry zero deltas so that pure button changes and silent packets occur.
  // Junk after the fourth byte is not counted, since the block drops it.
  function automatic void add_mouse_traffic(input int n);
    logic [7:0] hdr;
    logic [7:0] d1;
    logic [7:0] d2;
    int         added;
    int         pick;
    int         extra;
    added = 0;
    while (added < n) begin
      pick = $urandom_range(99);
      hdr = 8'($urandom);
      d1 = 8'($urandom);
      d2 = 8'($urandom);
      hdr[smpd_pkg::SYNC_BIT] = 1'b1;
      d1[smpd_pkg::SYNC_BIT] = 1'b0;
      d2[smpd_pkg::SYNC_BIT] = 1'b0;
      if ($urandom_range(3) == 0) begin
        hdr[3:0] = 4'h0;
        d1[5:0] = 6'h00;
        d2[5:0] = 6'h00;
      end
      if (pick < 72) begin
        byte_q.push_back(hdr);
        byte_q.push_back(d1);
        byte_q.push_back(d2);
        added += 3;
        if ($urandom_range(4) == 0) begin
          byte_q.push_back(8'($urandom) & ~8'h40);
          added++;
          extra = $urandom_range(2);
          repeat (extra) byte_q.push_back(8'($urandom) & ~8'h40);
        end
      end else if (pick < 88) begin
        // Cut short: the header of the next packet carries the sync bit.
        byte_q.push_back(hdr);
        added++;
        if ($urandom_range(1)) begin
          byte_q.push_back(d1);
          added++;
        end
      end else begin
        byte_q.push_back(8'($urandom));
        added++;
      end
    end
  endfunction

  // Waits until every queued byte has been taken and every predicted event
  // has come back.
  task automatic wait_drained();
    while (byte_q.size() != 0 || offering || pending_events.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic run_phase(input int s_idle, input int r_stall, input int n_items,
                           input bit long_hold);
    send_idle_pct = s_idle;
    recv_stall_pct = r_stall;
    if (long_hold) hold_req = 1'b1;
    add_mouse_traffic(n_items);
    wait_drained();
  endtask

  // Sender. Once a request is offered it stays on the bus unchanged until it
  // is taken; between requests the line idles at the phase's rate and the
  // byte lines carry junk.
  always @(negedge clk_i) begin
    if (running && !offering && byte_q.size() != 0 &&
        $urandom_range(99) >= send_idle_pct)
      offering = 1'b1;
    rx_ch.valid <= offering;
    rx_ch.rx_byte <= offering ? byte_q[0] : 8'($urandom);
  end

  // Receiver. A hold-off request turns into a counted stretch of low ready;
  // otherwise ready drops at the phase's stall rate.
  always @(negedge clk_i) begin
    if (!running) begin
      ev_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      ev_ch.ready <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      ev_ch.ready <= 1'b0;
      hold_left = HOLD_CYCLES - 1;
      hold_req = 1'b0;
    end else begin
      ev_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor. Events are checked before the byte of the same edge is decoded;
  // a byte can never cause an event at the edge on which it is taken.
  always @(posedge clk_i) begin : monitor
    mouse_ev_t want;
    if (running && ev_ch.valid && ev_ch.ready) begin
      events_seen++;
      if (pending_events.size() == 0) begin
        $error("unexpected event: event_kind %0d button_id %0d delta_x %0d delta_y %0d",
               ev_ch.event_kind, ev_ch.button_id, ev_ch.delta_x, ev_ch.delta_y);
        err_count++;
      end else begin
        want = pending_events.pop_front();
        if (want.kind == smpd_pkg::EV_MOVE) moves_seen++;
        else button_events_seen++;
        check_field("event_kind", {7'd0, want.kind}, {7'd0, ev_ch.event_kind});
        check_field("button_id", {7'd0, want.btn}, {7'd0, ev_ch.button_id});
        check_field("delta_x", want.dx, ev_ch.delta_x);
        check_field("delta_y", want.dy, ev_ch.delta_y);
        check_field("last", {8'd0, want.last}, {8'd0, ev_ch.last});
      end
    end
    if (running && rx_ch.valid && rx_ch.ready) begin
      byte_q.delete(0);
      offering = 1'b0;
      bytes_taken++;
      decode_rx_byte(rx_ch.rx_byte);
    end
  end

  // Directed packets, in order: a first packet whose header lacks the sync bit
  // and gives the most negative X; button 1 down with movement; button 2 down
  // alone; both buttons up with movement of minus one (three events from one
  // byte); a fourth byte and an ignored fifth; a packet broken by a sync
  // mid-packet followed by a full one with two button changes and movement;
  // a silent packet with no change and no movement; a header of all ones.
  logic [7:0] directed_bytes[25] = '{
    8'h02, 8'h00, 8'h00,
    8'h60, 8'h01, 8'h3F,
    8'h70, 8'h00, 8'h00,
    8'h4F, 8'h3F, 8'h3F,
    8'h00, 8'h3F,
    8'h70, 8'h05, 8'h7C, 8'h02, 8'h30,
    8'h70, 8'h00, 8'h00,
    8'hFF, 8'h80, 8'hBF
  };

  initial begin
    rst_ni = 1'b0;
    running = 1'b0;
    offering = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b0;
    hold_left = 0;
    cycle_count = 0;
    err_count = 0;
    bytes_taken = 0;
    packets_done = 0;
    events_seen = 0;
    moves_seen = 0;
    button_events_seen = 0;
    pkt_pos = smpd_pkg::POS_HEADER;
    hdr_byte = 8'h00;
    mid_byte = 8'h00;
    btn_prev = 2'b00;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = 8'h00;
    ev_ch.ready = 1'b0;

    // Reset is asserted first and released on a falling edge.
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    running <= 1'b1;

    // Directed part with light idling on both sides.
    send_idle_pct = 20;
    recv_stall_pct = 20;
    foreach (directed_bytes[i]) byte_q.push_back(directed_bytes[i]);
    wait_drained();

    // Random part: no idling, sender idle, receiver stalling, both, and then a
    // long receiver hold-off while the sender keeps offering requests.
    run_phase(0, 0, 80, 1'b0);
    run_phase(71, 0, 80, 1'b0);
    run_phase(0, 71, 80, 1'b0);
    run_phase(28, 28, 50, 1'b0);
    run_phase(0, 0, 35, 1'b1);

    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Decoded %0d bytes into %0d complete packets in %0d cycles.",
             bytes_taken, packets_done, cycle_count);
    $display("Checked %0d events: %0d button changes and %0d moves, %0d errors.",
             events_seen, button_events_seen, moves_seen, err_count);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/smpd_pkg.sv
src/smpd_if.sv
src/smpd_decode.sv
src/smpd_emit.sv
src/serial_mouse_packet_decoder_top.sv
src/smpd_checker.sv
tb/serial_mouse_packet_decoder_top_test.sv
